[hw/rtl/tsra_pkg.sv]
// Shared types and constants for the thermocouple serial reader and averager.
`timescale 1ns / 1ps

package tsra_pkg;

    // Serial framing
    localparam int FRAME_W  = 16;
    localparam int BCNT_W   = $clog2(FRAME_W);
    localparam int FAULT_BIT = 2;
    localparam int CODE_LSB = 3;
    localparam int CODE_W   = 12;

    // Calibration and scaling
    localparam int COEFF_W     = 16;
    localparam int SCALE_SHIFT = 8;
    localparam int READING_W   = CODE_W + COEFF_W - SCALE_SHIFT + 1;
    localparam logic [COEFF_W-1:0] COEFF_RESET = COEFF_W'(1024);
    localparam int FAULT_C = -1600;
    localparam logic signed [READING_W-1:0] FAULT_Q4 = READING_W'(FAULT_C);

    // Group mean
    localparam int AVG_COUNT  = 5;
    localparam int CNT_W      = $clog2(AVG_COUNT + 1);
    localparam int SUM_W      = 24;
    localparam int MAG_W      = SUM_W - 1;
    localparam int DIV_SHIFT  = 28;
    localparam int RECIP_W    = DIV_SHIFT + 1;
    localparam int RECIP_C    = (2**DIV_SHIFT + AVG_COUNT - 1) / AVG_COUNT;

    typedef struct packed {
        logic               valid;
        logic [FRAME_W-1:0] frame;
    } frame_beat_t;

    typedef struct packed {
        logic                        valid;
        logic signed [READING_W-1:0] reading;
        logic                        fault;
    } reading_beat_t;

endpackage

[hw/rtl/tsra_frame.sv]
// Serial shift register and 16-bit frame assembly.
`timescale 1ns / 1ps

module tsra_frame (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  miso_bit,
    input  logic                  first_bit,
    output tsra_pkg::frame_beat_t frame_out,
    input  logic                  frame_ready
);

    logic [tsra_pkg::FRAME_W-1:0] frame_shift_reg;
    logic [tsra_pkg::FRAME_W-1:0] frame_shift_next;
    logic [tsra_pkg::BCNT_W-1:0]  bit_count_reg;
    logic [tsra_pkg::BCNT_W-1:0]  bit_count_next;
    logic                         frame_valid_reg;
    logic [tsra_pkg::FRAME_W-1:0] frame_data_reg;
    logic                         in_accept;
    logic                         frame_done;

    assign in_ready  = !frame_valid_reg || frame_ready;
    assign in_accept = in_valid && in_ready;

    // A restart drops any partial frame; this bit becomes the top bit
    always_comb
    begin
        if (first_bit)
        begin
            frame_shift_next = {{(tsra_pkg::FRAME_W-1){1'b0}}, miso_bit};
            bit_count_next   = tsra_pkg::BCNT_W'(1);
        end
        else
        begin
            frame_shift_next = {frame_shift_reg[tsra_pkg::FRAME_W-2:0], miso_bit};
            bit_count_next   = bit_count_reg + 1'b1;
        end
    end

    assign frame_done = in_accept && (bit_count_next == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg <= '0;
            bit_count_reg   <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                frame_shift_reg <= frame_shift_next;
                bit_count_reg   <= bit_count_next;
            end
            if (frame_done)
                frame_valid_reg <= 1'b1;
            else if (frame_ready)
                frame_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_done)
            frame_data_reg <= frame_shift_next;
    end

    assign frame_out = '{valid: frame_valid_reg, frame: frame_data_reg};

endmodule

[hw/rtl/tsra_scale.sv]
// Fault decode and calibration scaling of one frame into a reading.
`timescale 1ns / 1ps

module tsra_scale (
    input  logic                         clk,
    input  logic                         rst_n,
    input  tsra_pkg::frame_beat_t        frame_in,
    output logic                         frame_ready,
    input  logic [tsra_pkg::COEFF_W-1:0] coeff,
    output tsra_pkg::reading_beat_t      reading_out,
    input  logic                         reading_ready
);

    localparam int PROD_W = tsra_pkg::CODE_W + tsra_pkg::COEFF_W;

    logic [tsra_pkg::CODE_W-1:0]            code;
    logic [PROD_W-1:0]                      product;
    logic                                   fault;
    logic signed [tsra_pkg::READING_W-1:0]  reading_next;
    logic                                   valid_reg;
    logic signed [tsra_pkg::READING_W-1:0]  reading_reg;
    logic                                   fault_reg;

    assign frame_ready = !valid_reg || reading_ready;

    // Bit 15 is the dummy bit: take the code from bits 14..3 only
    assign code    = frame_in.frame[tsra_pkg::CODE_LSB+tsra_pkg::CODE_W-1:tsra_pkg::CODE_LSB];
    assign product = {{tsra_pkg::COEFF_W{1'b0}}, code} * {{tsra_pkg::CODE_W{1'b0}}, coeff};
    assign fault   = frame_in.frame[tsra_pkg::FAULT_BIT];

    always_comb
    begin
        if (fault)
            reading_next = tsra_pkg::FAULT_Q4;
        else
            reading_next = {1'b0, product[PROD_W-1:tsra_pkg::SCALE_SHIFT]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (frame_ready)
            valid_reg <= frame_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (frame_ready && frame_in.valid)
        begin
            reading_reg <= reading_next;
            fault_reg   <= fault;
        end
    end

    assign reading_out = '{valid: valid_reg, reading: reading_reg, fault: fault_reg};

endmodule

[hw/rtl/tsra_mean.sv]
// Group accumulator, divide by the group size and the result register.
`timescale 1ns / 1ps

module tsra_mean (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tsra_pkg::reading_beat_t               reading_in,
    output logic                                  reading_ready,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tsra_pkg::READING_W-1:0] celsius_q4,
    output logic                                  open_fault,
    output logic                                  mean_ready,
    output logic signed [tsra_pkg::READING_W-1:0] mean_q4
);

    localparam int QPROD_W = tsra_pkg::MAG_W + tsra_pkg::RECIP_W;
    localparam logic [tsra_pkg::RECIP_W-1:0] RECIP = tsra_pkg::RECIP_W'(tsra_pkg::RECIP_C);
    localparam logic [tsra_pkg::CNT_W-1:0]   GROUP = tsra_pkg::CNT_W'(tsra_pkg::AVG_COUNT);

    // Accumulator state
    logic signed [tsra_pkg::SUM_W-1:0]     sum_reg;
    logic [tsra_pkg::CNT_W-1:0]            count_reg;
    logic signed [tsra_pkg::SUM_W-1:0]     total_next;
    logic [tsra_pkg::CNT_W-1:0]            count_next;
    logic                                  done_next;

    // Stage: group total
    logic                                  v3_reg;
    logic signed [tsra_pkg::READING_W-1:0] reading3_reg;
    logic                                  fault3_reg;
    logic                                  done3_reg;
    logic signed [tsra_pkg::SUM_W-1:0]     total3_reg;
    // Stage: magnitude and sign
    logic                                  v4_reg;
    logic signed [tsra_pkg::READING_W-1:0] reading4_reg;
    logic                                  fault4_reg;
    logic                                  done4_reg;
    logic                                  neg4_reg;
    logic [tsra_pkg::MAG_W-1:0]            mag4_reg;
    logic [tsra_pkg::SUM_W-1:0]            abs_next;
    // Stage: reciprocal multiply
    logic                                  v5_reg;
    logic signed [tsra_pkg::READING_W-1:0] reading5_reg;
    logic                                  fault5_reg;
    logic                                  done5_reg;
    logic                                  neg5_reg;
    logic [tsra_pkg::READING_W-1:0]        quo5_reg;
    logic [QPROD_W-1:0]                    qprod;
    logic signed [tsra_pkg::READING_W-1:0] mean_next;
    // Result register
    logic                                  out_valid_reg;
    logic signed [tsra_pkg::READING_W-1:0] celsius_reg;
    logic                                  fault_reg;
    logic                                  mean_ready_reg;
    logic signed [tsra_pkg::READING_W-1:0] mean_q4_reg;

    logic rdy3;
    logic rdy4;
    logic rdy5;
    logic rdy_out;
    logic take3;

    assign rdy_out       = !out_valid_reg || out_ready;
    assign rdy5          = !v5_reg || rdy_out;
    assign rdy4          = !v4_reg || rdy5;
    assign rdy3          = !v3_reg || rdy4;
    assign reading_ready = rdy3;
    assign take3         = rdy3 && reading_in.valid;

    assign total_next = sum_reg + tsra_pkg::SUM_W'(reading_in.reading);
    assign count_next = count_reg + 1'b1;
    assign done_next  = (count_next >= GROUP);

    // Accumulate; clear on the reading that closes the group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (take3)
        begin
            if (done_next)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
            end
            else
            begin
                sum_reg   <= total_next;
                count_reg <= count_next;
            end
        end
    end

    assign abs_next  = total3_reg[tsra_pkg::SUM_W-1] ? -total3_reg : total3_reg;
    assign qprod     = {{tsra_pkg::RECIP_W{1'b0}}, mag4_reg} * {{tsra_pkg::MAG_W{1'b0}}, RECIP};
    assign mean_next = neg5_reg ? -quo5_reg : quo5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            mean_q4_reg   <= '0;
        end
        else
        begin
            if (rdy3)
                v3_reg <= reading_in.valid;
            if (rdy4)
                v4_reg <= v3_reg;
            if (rdy5)
                v5_reg <= v4_reg;
            if (rdy_out)
                out_valid_reg <= v5_reg;
            // Hold the last mean until the next group closes
            if (rdy_out && v5_reg && done5_reg)
                mean_q4_reg <= mean_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take3)
        begin
            reading3_reg <= reading_in.reading;
            fault3_reg   <= reading_in.fault;
            done3_reg    <= done_next;
            total3_reg   <= total_next;
        end
        if (rdy4 && v3_reg)
        begin
            reading4_reg <= reading3_reg;
            fault4_reg   <= fault3_reg;
            done4_reg    <= done3_reg;
            neg4_reg     <= total3_reg[tsra_pkg::SUM_W-1];
            mag4_reg     <= abs_next[tsra_pkg::MAG_W-1:0];
        end
        if (rdy5 && v4_reg)
        begin
            reading5_reg <= reading4_reg;
            fault5_reg   <= fault4_reg;
            done5_reg    <= done4_reg;
            neg5_reg     <= neg4_reg;
            quo5_reg     <= qprod[tsra_pkg::DIV_SHIFT+tsra_pkg::READING_W-1:tsra_pkg::DIV_SHIFT];
        end
        if (rdy_out && v5_reg)
        begin
            celsius_reg    <= reading5_reg;
            fault_reg      <= fault5_reg;
            mean_ready_reg <= done5_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign celsius_q4 = celsius_reg;
    assign open_fault = fault_reg;
    assign mean_ready = mean_ready_reg;
    assign mean_q4    = mean_q4_reg;

endmodule

[hw/rtl/thermocouple_serial_reader_averager_top.sv]
// Top level of the thermocouple serial reader with group mean.
`timescale 1ns / 1ps
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  input    | in_valid / in_ready    | miso_bit, first_bit
//  result   | out_valid / out_ready  | celsius_q4, open_fault, mean_ready, mean_q4
//  config   | cfg_wr_en (no wait)    | cfg_wr_data (calibration coefficient, Q8.8)
//
//  One bit beat is taken every cycle while in_ready is high; a result beat leaves
//  after every sixteenth bit of a frame, six register stages after its closing bit
//  beat (frame, scale multiply, group total, magnitude, reciprocal multiply, result).
//  Reset clears the shift register, bit count, group sum and count, the
//  held mean and all valid flags; the coefficient returns to 4.0.
//  Each stage holds its beat while the one after it is full, so a stall on
//  the result side fills the empty stages before in_ready drops.

module thermocouple_serial_reader_averager_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  miso_bit,
    input  logic                                  first_bit,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [tsra_pkg::READING_W-1:0] celsius_q4,
    output logic                                  open_fault,
    output logic                                  mean_ready,
    output logic signed [tsra_pkg::READING_W-1:0] mean_q4,
    input  logic                                  cfg_wr_en,
    input  logic [tsra_pkg::COEFF_W-1:0]          cfg_wr_data
);

    logic [tsra_pkg::COEFF_W-1:0] coeff_reg;
    tsra_pkg::frame_beat_t        frame_beat;
    logic                         frame_ready;
    tsra_pkg::reading_beat_t      reading_beat;
    logic                         reading_ready;

    // Calibration coefficient: user must write only while the block is idle; unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            coeff_reg <= tsra_pkg::COEFF_RESET;
        else if (cfg_wr_en)
            coeff_reg <= cfg_wr_data;
    end

    // Shift in bits and close a frame every sixteenth beat
    tsra_frame u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .miso_bit    (miso_bit),
        .first_bit   (first_bit),
        .frame_out   (frame_beat),
        .frame_ready (frame_ready)
    );

    // Decode the fault flag and scale the code by the coefficient
    tsra_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .frame_in      (frame_beat),
        .frame_ready   (frame_ready),
        .coeff         (coeff_reg),
        .reading_out   (reading_beat),
        .reading_ready (reading_ready)
    );

    // Accumulate groups, divide by the group size, present the result
    tsra_mean u_mean (
        .clk           (clk),
        .rst_n         (rst_n),
        .reading_in    (reading_beat),
        .reading_ready (reading_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .celsius_q4    (celsius_q4),
        .open_fault    (open_fault),
        .mean_ready    (mean_ready),
        .mean_q4       (mean_q4)
    );

    // A fault result always carries the fixed open-circuit reading
    a_fault_reading: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && open_fault |-> celsius_q4 == tsra_pkg::FAULT_Q4)
        else $error("fault result without fault reading");

    // A scaled reading is never negative
    a_scaled_positive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !open_fault |-> !celsius_q4[tsra_pkg::READING_W-1])
        else $error("scaled reading negative");

    // A restart bit can never close a frame
    a_restart_no_frame: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && first_bit |=> !frame_beat.valid || $past(frame_beat.valid))
        else $error("frame closed on restart bit");

    // A frame beat waiting downstream blocks the input only when the scale stage is full
    a_input_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> frame_beat.valid && !frame_ready)
        else $error("input stalled without a full frame stage");

endmodule

[tb/thermocouple_serial_reader_averager_top_tb.sv]
// Self-checking testbench for the thermocouple serial reader with group mean.
`timescale 1ns / 1ps

module thermocouple_serial_reader_averager_top_tb;

    // Cycles to let the result pipeline settle once nothing is expected:
    // six register stages plus margin.
    localparam int SETTLE_CYCLES = 16;
    // About 200 directed bit beats come first; the random phases bring the
    // total to roughly 1300.
    localparam int RANDOM_ITEMS  = 1100;
    localparam int PHASE_ITEMS   = RANDOM_ITEMS / 4;

    // ------------------------------------------------------------------
    // Scoreboard: predicts the reading and group mean for each frame and
    // checks every result beat against the oldest prediction.
    // ------------------------------------------------------------------
    class reading_scoreboard;

        typedef struct {
            logic signed [tsra_pkg::READING_W-1:0] celsius;
            logic                                  fault;
            logic                                  mready;
            logic signed [tsra_pkg::READING_W-1:0] mean;
        } reading_t;

        logic [tsra_pkg::COEFF_W-1:0]          coeff;
        logic [tsra_pkg::FRAME_W-1:0]          shift_q;
        logic [tsra_pkg::BCNT_W-1:0]           bits_seen;
        int                                    group_sum;
        int                                    group_len;
        logic signed [tsra_pkg::READING_W-1:0] held_mean;
        reading_t                              expected_readings[$];
        int                                    mismatches;
        int                                    checked;
        int                                    frames_seen;
        int                                    means_seen;

        function new();
            coeff       = tsra_pkg::COEFF_RESET;
            shift_q     = '0;
            bits_seen   = '0;
            group_sum   = 0;
            group_len   = 0;
            held_mean   = '0;
            mismatches  = 0;
            checked     = 0;
            frames_seen = 0;
            means_seen  = 0;
        endfunction

        function void set_coeff(logic [tsra_pkg::COEFF_W-1:0] v);
            coeff = v;
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // Shift in one accepted bit beat; predict a reading when a frame closes.
        function void take_bit(logic b, logic f);
            reading_t                    r;
            int unsigned                 prod;
            logic [tsra_pkg::CODE_W-1:0] code;
            int                          rd;
            if (f)
            begin
                shift_q   = '0;
                bits_seen = '0;
            end
            shift_q   = {shift_q[tsra_pkg::FRAME_W-2:0], b};
            bits_seen = bits_seen + 1'b1;
            if (bits_seen != '0)
                return;
            r.fault = shift_q[tsra_pkg::FAULT_BIT];
            if (r.fault)
                rd = tsra_pkg::FAULT_C;
            else
            begin
                // Dummy bit 15 is dropped: the code is bits 14..3
                code = shift_q[tsra_pkg::CODE_LSB +: tsra_pkg::CODE_W];
                prod = 32'(code) * 32'(coeff);
                rd   = int'(prod >> tsra_pkg::SCALE_SHIFT);
            end
            group_sum += rd;
            group_len++;
            r.mready = 1'b0;
            if (group_len >= tsra_pkg::AVG_COUNT)
            begin
                // Integer division truncates toward zero
                held_mean = tsra_pkg::READING_W'(group_sum / tsra_pkg::AVG_COUNT);
                group_sum = 0;
                group_len = 0;
                r.mready  = 1'b1;
                means_seen++;
            end
            r.celsius = tsra_pkg::READING_W'(rd);
            r.mean    = held_mean;
            expected_readings.push_back(r);
            frames_seen++;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch: %s", $realtime, msg);
        endfunction

        function void check_reading(logic signed [tsra_pkg::READING_W-1:0] c, logic f,
                                    logic mr, logic signed [tsra_pkg::READING_W-1:0] m);
            reading_t e;
            if (expected_readings.size() == 0)
            begin
                note_mismatch($sformatf(
                    "unexpected result celsius=%0d fault=%0b mean_ready=%0b mean=%0d",
                    c, f, mr, m));
                return;
            end
            e = expected_readings.pop_front();
            checked++;
            if (c !== e.celsius || f !== e.fault || mr !== e.mready || m !== e.mean)
                note_mismatch($sformatf(
                    {"result %0d: exp celsius=%0d fault=%0b mean_ready=%0b mean=%0d",
                     " got celsius=%0d fault=%0b mean_ready=%0b mean=%0d"},
                    checked, e.celsius, e.fault, e.mready, e.mean, c, f, mr, m));
        endfunction

    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_ready;
    logic                                  miso_bit = 1'b0;
    logic                                  first_bit = 1'b0;
    logic                                  out_valid;
    logic                                  out_ready = 1'b0;
    logic signed [tsra_pkg::READING_W-1:0] celsius_q4;
    logic                                  open_fault;
    logic                                  mean_ready;
    logic signed [tsra_pkg::READING_W-1:0] mean_q4;
    logic                                  cfg_wr_en = 1'b0;
    logic [tsra_pkg::COEFF_W-1:0]          cfg_wr_data = '0;

    // Idling switches for the two sides; cleared for the no-idle stretch
    bit in_idle_on  = 1'b1;
    bit out_idle_on = 1'b1;

    int items_sent = 0;
    int cfg_writes = 0;

    reading_scoreboard sb;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    thermocouple_serial_reader_averager_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .miso_bit    (miso_bit),
        .first_bit   (first_bit),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .celsius_q4  (celsius_q4),
        .open_fault  (open_fault),
        .mean_ready  (mean_ready),
        .mean_q4     (mean_q4),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Result side: stall about a quarter of cycles unless idling is off.
    always @(negedge clk)
        out_ready <= !out_idle_on || ($urandom_range(99) >= 25);

    // Check every accepted result beat at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_reading(celsius_q4, open_fault, mean_ready, mean_q4);
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Present one bit beat, hold it until accepted, then note it.
    task automatic send_bit(logic b, logic f);
        while (in_idle_on && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        miso_bit  <= b;
        first_bit <= f;
        do
            @(posedge clk);
        while (!in_ready);
        sb.take_bit(b, f);
        items_sent++;
        @(negedge clk);
    endtask

    // Send a 16-bit frame MSB first, optionally marking the restart.
    task automatic send_frame(logic [tsra_pkg::FRAME_W-1:0] fr, bit with_first);
        for (int i = tsra_pkg::FRAME_W - 1; i >= 0; i--)
            send_bit(fr[i], with_first && (i == tsra_pkg::FRAME_W - 1));
    endtask

    // Drain all outstanding results, let the pipeline settle, then write.
    task automatic set_calibration(logic [tsra_pkg::COEFF_W-1:0] v);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_coeff(v);
        cfg_writes++;
    endtask

    function automatic logic [tsra_pkg::FRAME_W-1:0] make_frame(
        logic dummy, logic [tsra_pkg::CODE_W-1:0] code, logic fault, logic [1:0] low);
        return {dummy, code, fault, low};
    endfunction

    // Random content with a fault about one frame in five
    function automatic logic [tsra_pkg::FRAME_W-1:0] random_frame();
        logic [tsra_pkg::FRAME_W-1:0] fr;
        fr = tsra_pkg::FRAME_W'($urandom);
        fr[tsra_pkg::FAULT_BIT] = ($urandom_range(99) < 20);
        return fr;
    endfunction

    // Mostly well-formed frames; the rest free-running frames and noise
    task automatic run_phase(int n_items);
        int start;
        int pick;
        int len;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_frame(random_frame(), 1'b1);
            else if (pick < 85)
                send_frame(random_frame(), 1'b0);
            else
            begin
                len = $urandom_range(1, 20);
                repeat (len) send_bit(1'($urandom), $urandom_range(9) == 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // First group at the reset coefficient: zero code, full code, dummy bit
        // set, faults with code bits present; mean truncates a positive sum.
        send_frame(make_frame(1'b0, 12'h000, 1'b0, 2'b00), 1'b1);
        send_frame(make_frame(1'b0, 12'hFFF, 1'b0, 2'b11), 1'b1);
        send_frame(make_frame(1'b1, 12'h123, 1'b0, 2'b01), 1'b1);
        send_frame(make_frame(1'b0, 12'hABC, 1'b1, 2'b10), 1'b1);
        // Restart: drop a partial frame, then a full fault frame
        repeat (7) send_bit(1'b1, 1'b0);
        send_frame(make_frame(1'b1, 12'hFFF, 1'b1, 2'b11), 1'b1);
        // Second group: four faults and a tiny reading, negative mean
        repeat (4) send_frame(make_frame(1'b0, 12'h001, 1'b1, 2'b00), 1'b1);
        send_frame(make_frame(1'b0, 12'h001, 1'b0, 2'b00), 1'b1);

        // Largest coefficient: full code gives the largest reading
        set_calibration('1);
        repeat (2) send_frame(make_frame(1'b1, 12'hFFF, 1'b0, 2'b11), 1'b1);
        run_phase(PHASE_ITEMS);

        // Zero coefficient: every good frame reads zero
        set_calibration('0);
        run_phase(PHASE_ITEMS);

        // Long stretch with no idling on either side
        set_calibration(tsra_pkg::COEFF_W'($urandom));
        in_idle_on  = 1'b0;
        out_idle_on = 1'b0;
        run_phase(PHASE_ITEMS);
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;

        set_calibration(tsra_pkg::COEFF_W'($urandom_range(1, 16'h2000)));
        run_phase(PHASE_ITEMS);

        // Drop valid, wait for the last results, then let the pipeline settle
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d bit beats, %0d frames, %0d group means, %0d coefficient %s",
                 items_sent, sb.frames_seen, sb.means_seen, cfg_writes, "writes.");
        $display("Checked %0d result beats, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("[thermocouple_serial_reader_averager_top] OK");
        else
            $display("[thermocouple_serial_reader_averager_top] ERROR");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still expected.", sb.pending());
        $display("[thermocouple_serial_reader_averager_top] ERROR");
        $finish;
    end

endmodule
